[hw/rtl/tf256_pkg.sv]
// ----------------------------------------------------------------------------
// tf256_pkg
// Shared constants and round functions for the Threefish-256 pipeline.
// ----------------------------------------------------------------------------
package tf256_pkg;

  localparam int unsigned Rounds     = 72;
  localparam int unsigned Subkeys    = Rounds / 4 + 1;
  localparam int unsigned WordW      = 64;
  localparam int unsigned CfgIdxW    = 2;
  localparam logic [63:0] KeyParity  = 64'h1BD11BDAA9FC1A22;

  localparam logic [CfgIdxW-1:0] REG_KEY0 = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1 = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3 = 2'd3;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  typedef logic [63:0] word_t;
  typedef word_t [3:0] blk_t;
  typedef word_t [4:0] key_t;
  typedef word_t [2:0] twk_t;

  typedef struct packed {
    logic  dec;
    blk_t  v;
    key_t  k;
    twk_t  t;
  } stage_t;

  function automatic logic [5:0] rot_amt(input logic [3:0] r);
    logic [5:0] res;
    begin
      case (r)
        4'd0:  res = 6'd14;
        4'd1:  res = 6'd16;
        4'd2:  res = 6'd52;
        4'd3:  res = 6'd57;
        4'd4:  res = 6'd23;
        4'd5:  res = 6'd40;
        4'd6:  res = 6'd5;
        4'd7:  res = 6'd37;
        4'd8:  res = 6'd25;
        4'd9:  res = 6'd33;
        4'd10: res = 6'd46;
        4'd11: res = 6'd12;
        4'd12: res = 6'd58;
        4'd13: res = 6'd22;
        4'd14: res = 6'd32;
        default: res = 6'd32;
      endcase
      return res;
    end
  endfunction

  function automatic word_t rotl(input word_t x, input logic [5:0] n);
    logic [127:0] w;
    begin
      w = {x, x} << n;
      return w[127:64];
    end
  endfunction

  function automatic word_t rotr(input word_t x, input logic [5:0] n);
    logic [127:0] w;
    begin
      w = {x, x} >> n;
      return w[63:0];
    end
  endfunction

  // subkey s (0..18), word i
  function automatic blk_t subkey(input key_t k, input twk_t t, input int unsigned s);
    blk_t r;
    begin
      r[0] = k[s % 5];
      r[1] = k[(s + 1) % 5] + t[s % 3];
      r[2] = k[(s + 2) % 5] + t[(s + 1) % 3];
      r[3] = k[(s + 3) % 5] + word_t'(s);
      return r;
    end
  endfunction

  // forward round d
  function automatic blk_t enc_round(input blk_t vi, input int unsigned d);
    blk_t v;
    int unsigned b0, b1, r;
    begin
      v  = vi;
      b0 = (d % 2 == 1) ? 3 : 1;
      b1 = (d % 2 == 1) ? 1 : 3;
      r  = (d % 8) * 2;
      v[0]  = v[0] + v[b0];
      v[b0] = rotl(v[b0], rot_amt(4'(r))) ^ v[0];
      v[2]  = v[2] + v[b1];
      v[b1] = rotl(v[b1], rot_amt(4'(r + 1))) ^ v[2];
      return v;
    end
  endfunction

  // inverse of round d
  function automatic blk_t dec_round(input blk_t vi, input int unsigned d);
    blk_t v;
    int unsigned b0, b1, r;
    begin
      v  = vi;
      b0 = (d % 2 == 1) ? 3 : 1;
      b1 = (d % 2 == 1) ? 1 : 3;
      r  = (d % 8) * 2;
      v[b1] = rotr(v[b1] ^ v[2], rot_amt(4'(r + 1)));
      v[2]  = v[2] - v[b1];
      v[b0] = rotr(v[b0] ^ v[0], rot_amt(4'(r)));
      v[0]  = v[0] - v[b0];
      return v;
    end
  endfunction

  function automatic blk_t blk_add(input blk_t a, input blk_t b);
    blk_t r;
    begin
      for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
      return r;
    end
  endfunction

  function automatic blk_t blk_sub(input blk_t a, input blk_t b);
    blk_t r;
    begin
      for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
      return r;
    end
  endfunction

endpackage

[hw/rtl/threefish256_block_cipher_unit.sv]
// ----------------------------------------------------------------------------
// threefish256_block_cipher_unit
// Fully unrolled Threefish-256 encrypt/decrypt pipeline.
// ----------------------------------------------------------------------------
// Usage:
//  - Key words are written on the cfg_ port (index 0..3, other indexes are
//    dropped) while the pipeline is empty. Keys reset to zero.
//  - Input transfer: in_valid & in_ready carries func (0 enc, 1 dec), four
//    data words and two tweak words. Output transfer: out_valid & out_ready
//    carries four result words.
//  - Pipeline: one entry stage (key/tweak expansion, initial subkey for
//    encrypt), then 18 stages of four rounds plus subkey each, all registered.
//    Encrypt and decrypt share the stages; each stage holds both a forward
//    and an inverse datapath and picks by the item's func bit. Decrypt items
//    walk the stage list in reverse round order, finishing with the subkey-zero
//    removal at the last stage.
//  - Throughput: one block per cycle when not stalled. Each stage advances when
//    its slot is empty or the stage after it moves; a stall on out_ready backs
//    up the pipe stage by stage without dropping or duplicating items.
//  - Reset (synchronous, rst_n low) clears all valid bits and the keys.
// ----------------------------------------------------------------------------
module threefish256_block_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [63:0] in_data_word0,
  input  logic [63:0] in_data_word1,
  input  logic [63:0] in_data_word2,
  input  logic [63:0] in_data_word3,
  input  logic [63:0] in_tweak_word0,
  input  logic [63:0] in_tweak_word1,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_word0,
  output logic [63:0] out_result_word1,
  output logic [63:0] out_result_word2,
  output logic [63:0] out_result_word3
);

  localparam int unsigned NumGroups = tf256_pkg::Subkeys - 1;
  localparam int unsigned NStg = NumGroups + 1;

  tf256_pkg::word_t [3:0] key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tf256_pkg::REG_KEY0: key_r[0] <= cfg_data;
        tf256_pkg::REG_KEY1: key_r[1] <= cfg_data;
        tf256_pkg::REG_KEY2: key_r[2] <= cfg_data;
        tf256_pkg::REG_KEY3: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  tf256_pkg::stage_t [NStg-1:0] stg_r;
  tf256_pkg::stage_t stg_nxt [NStg];
  logic [NStg-1:0] vld_r;
  logic [NStg-1:0] adv;

  // Backpressure: a stage loads when empty or when its content moves on.
  always_comb begin
    adv[NStg-1] = !vld_r[NStg-1] || out_ready;
    for (int s = NStg - 2; s >= 0; s--) adv[s] = !vld_r[s] || adv[s+1];
  end
  assign in_ready = adv[0];

  // Entry stage: key parity, third tweak word, encrypt whitening.
  always_comb begin
    tf256_pkg::key_t k;
    tf256_pkg::twk_t t;
    tf256_pkg::blk_t v;
    k[3:0] = key_r;
    k[4]   = tf256_pkg::KeyParity ^ key_r[0] ^ key_r[1] ^ key_r[2] ^ key_r[3];
    t[0]   = in_tweak_word0;
    t[1]   = in_tweak_word1;
    t[2]   = in_tweak_word0 ^ in_tweak_word1;
    v      = {in_data_word3, in_data_word2, in_data_word1, in_data_word0};
    stg_nxt[0].dec = in_func;
    stg_nxt[0].k   = k;
    stg_nxt[0].t   = t;
    stg_nxt[0].v   = (in_func == tf256_pkg::FUNC_ENC) ?
                     tf256_pkg::blk_add(v, tf256_pkg::subkey(k, t, 0)) : v;
  end

  // Round groups. Stage g (1..NumGroups) does encrypt rounds 4(g-1)..4g-1
  // plus subkey g, or decrypt of subkey NumGroups+1-g and its four rounds.
  for (genvar g = 1; g < NStg; g++) begin : g_grp
    always_comb begin
      tf256_pkg::stage_t p;
      tf256_pkg::blk_t ve, vd;
      p  = stg_r[g-1];
      ve = p.v;
      for (int j = 0; j < 4; j++) ve = tf256_pkg::enc_round(ve, 4 * (g - 1) + j);
      ve = tf256_pkg::blk_add(ve, tf256_pkg::subkey(p.k, p.t, g));
      vd = tf256_pkg::blk_sub(p.v, tf256_pkg::subkey(p.k, p.t, NStg - g));
      for (int j = 3; j >= 0; j--)
        vd = tf256_pkg::dec_round(vd, 4 * (NStg - 1 - g) + j);
      if (g == NStg - 1) vd = tf256_pkg::blk_sub(vd, tf256_pkg::subkey(p.k, p.t, 0));
      stg_nxt[g]   = p;
      stg_nxt[g].v = (p.dec == tf256_pkg::FUNC_DEC) ? vd : ve;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int s = 1; s < NStg; s++) if (adv[s]) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) stg_r[0] <= stg_nxt[0];
    for (int s = 1; s < NStg; s++) if (adv[s] && vld_r[s-1]) stg_r[s] <= stg_nxt[s];
  end

  assign out_valid        = vld_r[NStg-1];
  assign out_result_word0 = stg_r[NStg-1].v[0];
  assign out_result_word1 = stg_r[NStg-1].v[1];
  assign out_result_word2 = stg_r[NStg-1].v[2];
  assign out_result_word3 = stg_r[NStg-1].v[3];

  // A stalled output keeps its item.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output item lost during stall");

  // Input is refused only when the whole pipe is full and the output stalls.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r) && !out_ready)
    else $error("pipe refused input with a free slot");

  // A bubble at the last stage cannot show output next cycle unless fed.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NStg-1] && !vld_r[NStg-2] |=> !out_valid)
    else $error("output appeared from empty stages");

endmodule
